// ===== rtl/core/pcwa_pkg.sv =====
// Package for the prefix codeword assigner.
// Holds status codes, field widths and the codeword mask helper.
// No dependencies.
`timescale 1ns / 1ps

package pcwa_pkg;

  // Field widths
  localparam int LEN_W  = 6;
  localparam int CW_W   = 32;
  localparam int STAT_W = 3;
  localparam int IDX_W  = 8;
  localparam int MAX_LEN = 32;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_FREE    = 3'd2;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [STAT_W-1:0] ST_INCOMPLETE = 3'd4;

  // Mask of the top n bits, n from 1 to 32
  function automatic logic [CW_W-1:0] top_mask(input logic [LEN_W-1:0] n);
    return ~(32'hFFFF_FFFF >> n);
  endfunction

endpackage

// ===== rtl/core/prefix_codeword_assigner_top.sv =====
// Prefix codeword assigner: one codeword per codebook entry length. Depends on pcwa_pkg.
// Unused, oversized or table-full entries go from IDLE straight to FINISH; other entries
// go through LOOKUP, where an exhausted length finishes, else through SCAN passes over the
// stored entries, each collision restarting the scan with a bumped candidate, then FINISH.
// One entry in work at a time; the next is accepted once its result is registered, when
// the output is free. Reset (sync, active low) clears the FSM, counter and flags.
`timescale 1ns / 1ps

module prefix_codeword_assigner_top
  import pcwa_pkg::*;
#(
  parameter int MAX_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [5:0] entry_length, [7:6] zero
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,   // last_entry
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: [7:0] entry_index, [39:8] codeword, [42:40] status, [47:43] zero
  output logic [47:0] out_tdata,
  output logic        out_tlast,  // book_done
  output logic        out_tvalid,
  input  logic        out_tready
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int ENT_W  = LEN_W + CW_W;
  localparam int NFC_W  = CW_W + 1;
  localparam int NFC_D  = MAX_LEN + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  // Memories: stored entries {length, codeword}; next free {exhausted, code}
  logic [ENT_W-1:0] code_mem [MAX_ENTRIES];
  logic [NFC_W-1:0] nfc_mem  [NFC_D];

  logic [1:0]        state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              last_r, last_nxt;
  logic [CW_W-1:0]   cw_r, cw_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic              full_r, full_nxt;
  logic              succ_r, succ_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  scan_k_r, scan_k_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              ones_r, ones_nxt;
  logic [NFC_D-1:0]  nfc_vld_r, nfc_vld_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [CW_W-1:0]   out_cw_r, out_cw_nxt;
  logic [STAT_W-1:0] out_stat_r, out_stat_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory ports
  logic              code_we, code_re;
  logic [ADDR_W-1:0] code_waddr, code_raddr;
  logic [ENT_W-1:0]  code_wdata, code_rd_r;
  logic              nfc_we, nfc_re;
  logic [LEN_W-1:0]  nfc_raddr;
  logic [NFC_W-1:0]  nfc_wdata, nfc_rd_r;
  logic              nfc_hit_r;

  // Datapath helpers
  logic [LEN_W-1:0]  in_len;
  logic [NFC_W-1:0]  nfc_cur;
  logic [LEN_W-1:0]  rd_len, min_len;
  logic [CW_W-1:0]   rd_cw, cmp_mask, bump_cw;
  logic              collide;
  logic [CW_W-1:0]   len_mask;
  logic [NFC_W-1:0]  adv_sum;
  logic              ones_now, out_free;

  assign in_len    = in_tdata[LEN_W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign nfc_cur   = nfc_hit_r ? nfc_rd_r : '0;
  assign out_free  = !out_valid_r || out_tready;

  // Collision check of the candidate against one stored entry
  assign rd_len   = code_rd_r[ENT_W-1:CW_W];
  assign rd_cw    = code_rd_r[CW_W-1:0];
  assign min_len  = (rd_len < len_r) ? rd_len : len_r;
  assign cmp_mask = top_mask(min_len);
  assign collide  = (rd_len != '0) && ((rd_cw & cmp_mask) == (cw_r & cmp_mask));
  assign bump_cw  = (cw_r + (~cmp_mask + 32'd1)) & cmp_mask;

  // Advance of the next free codeword after a success
  assign len_mask = top_mask(len_r);
  assign adv_sum  = {1'b0, cw_r} + {1'b0, ~len_mask + 32'd1};
  assign ones_now = succ_r && (cw_r == len_mask);

  // Control and datapath next state
  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    last_nxt     = last_r;
    cw_nxt       = cw_r;
    stat_nxt     = stat_r;
    full_nxt     = full_r;
    succ_nxt     = succ_r;
    cnt_nxt      = cnt_r;
    scan_k_nxt   = scan_k_r;
    rd_pend_nxt  = rd_pend_r;
    ones_nxt     = ones_r;
    nfc_vld_nxt  = nfc_vld_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt  = out_idx_r;
    out_cw_nxt   = out_cw_r;
    out_stat_nxt = out_stat_r;
    out_last_nxt = out_last_r;
    code_we      = 1'b0;
    code_re      = 1'b0;
    code_waddr   = cnt_r[ADDR_W-1:0];
    code_raddr   = scan_k_r[ADDR_W-1:0];
    code_wdata   = {(succ_r ? len_r : {LEN_W{1'b0}}), (succ_r ? cw_r : {CW_W{1'b0}})};
    nfc_we       = 1'b0;
    nfc_re       = 1'b0;
    nfc_raddr    = in_len;
    nfc_wdata    = adv_sum;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          len_nxt     = in_len;
          last_nxt    = in_tlast;
          cw_nxt      = '0;
          succ_nxt    = 1'b0;
          scan_k_nxt  = '0;
          rd_pend_nxt = 1'b0;
          stat_nxt    = ST_OK;
          full_nxt    = 1'b0;
          state_nxt   = S_FINISH;
          if (cnt_r >= CNT_W'(MAX_ENTRIES)) begin
            full_nxt = 1'b1;
            stat_nxt = ST_TABLE_FULL;
          end else if (in_len > LEN_W'(MAX_LEN)) begin
            stat_nxt = ST_NO_FREE;
          end else if (in_len != '0) begin
            nfc_re    = 1'b1;
            state_nxt = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        if (nfc_cur[CW_W]) begin
          stat_nxt  = ST_EXHAUSTED;
          state_nxt = S_FINISH;
        end else begin
          cw_nxt    = nfc_cur[CW_W-1:0];
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue one read a cycle, compare the previous read's data
        if (scan_k_r < cnt_r) begin
          code_re     = 1'b1;
          scan_k_nxt  = scan_k_r + CNT_W'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
        end
        if (rd_pend_r && collide) begin
          rd_pend_nxt = 1'b0;
          if (bump_cw <= cw_r) begin
            stat_nxt  = ST_NO_FREE;
            state_nxt = S_FINISH;
          end else begin
            cw_nxt     = bump_cw;
            scan_k_nxt = '0;
          end
        end else if (!rd_pend_r && scan_k_r == cnt_r) begin
          succ_nxt  = 1'b1;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = IDX_W'(cnt_r);
          out_cw_nxt    = succ_r ? cw_r : '0;
          out_last_nxt  = last_r;
          out_stat_nxt  = stat_r;
          if (last_r && stat_r == ST_OK && !(ones_r || ones_now))
            out_stat_nxt = ST_INCOMPLETE;
          if (!full_r) begin
            code_we = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (succ_r) begin
            nfc_we              = 1'b1;
            nfc_vld_nxt[len_r]  = 1'b1;
          end
          ones_nxt = ones_r || ones_now;
          // end of book: back to the reset state
          if (last_r) begin
            cnt_nxt     = '0;
            nfc_vld_nxt = '0;
            ones_nxt    = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      ones_r      <= 1'b0;
      nfc_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      ones_r      <= ones_nxt;
      nfc_vld_r   <= nfc_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    last_r     <= last_nxt;
    cw_r       <= cw_nxt;
    stat_r     <= stat_nxt;
    full_r     <= full_nxt;
    succ_r     <= succ_nxt;
    scan_k_r   <= scan_k_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cw_r   <= out_cw_nxt;
    out_stat_r <= out_stat_nxt;
    out_last_r <= out_last_nxt;
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (code_we)
      code_mem[code_waddr] <= code_wdata;
    if (code_re)
      code_rd_r <= code_mem[code_raddr];
  end

  // Next-free memory; entries without a valid bit read as zero
  always_ff @(posedge clk) begin
    if (nfc_we)
      nfc_mem[len_r] <= nfc_wdata;
    if (nfc_re) begin
      nfc_rd_r  <= nfc_mem[nfc_raddr];
      nfc_hit_r <= nfc_vld_r[nfc_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {5'd0, out_stat_r, out_cw_r, out_idx_r};

endmodule

// ===== rtl/core/pcwa_checker.sv =====
// Port-level checker for the prefix codeword assigner, bound to the top.
// Depends on pcwa_pkg and prefix_codeword_assigner_top.
`timescale 1ns / 1ps

module pcwa_checker
  import pcwa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tvalid,
  input logic        out_tready
);

  logic [STAT_W-1:0] st;
  logic [CW_W-1:0]   cw;

  assign st = out_tdata[42:40];
  assign cw = out_tdata[39:8];

  // One entry in work at a time: input closes after each transaction
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still open after an accepted transaction");

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Failed entries carry no codeword
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == ST_EXHAUSTED || st == ST_NO_FREE || st == ST_TABLE_FULL)
      |-> cw == '0)
    else $error("nonzero codeword on failed entry");

  // Incomplete tree is only reported on the last entry
  a_incomplete_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_INCOMPLETE |-> out_tlast)
    else $error("incomplete status before end of book");

  // Status is one of the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> st <= ST_INCOMPLETE)
    else $error("undefined status code");

endmodule

bind prefix_codeword_assigner_top pcwa_checker u_pcwa_checker (.*);

// ===== test/codeword_checker.sv =====
// Checker for the prefix codeword assigner: watches both stream channels,
// predicts each result from its own copy of the book state and compares.
// Depends on pcwa_pkg for field widths and status codes.
`timescale 1ns / 1ps

module codeword_checker
  import pcwa_pkg::*;
#(
  parameter int MAX_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_tdata,     // [5:0] entry_length, [7:6] zero
  input  logic        in_tlast,     // last_entry
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] out_tdata,    // [7:0] index, [39:8] codeword, [42:40] status
  input  logic        out_tlast,    // book_done
  input  logic        out_tvalid,
  input  logic        out_tready,
  output int          mismatch_count,
  output int          pending_codewords
);

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [CW_W-1:0]   codeword;
    logic [STAT_W-1:0] status;
    logic              book_done;
  } codeword_result_t;

  // Book state as the block should hold it
  logic [CW_W-1:0]  stored_code [MAX_ENTRIES];
  logic [LEN_W-1:0] stored_len  [MAX_ENTRIES];
  logic [CW_W-1:0]  next_code   [MAX_LEN+1];
  bit               len_used_up [MAX_LEN+1];
  bit               all_ones_hit;
  logic [31:0]      entries_in_book;

  codeword_result_t expected_codewords [$];

  // Top n bits set, n from 1 to 32
  function automatic logic [CW_W-1:0] prefix_bits(input int unsigned n);
    return {CW_W{1'b1}} << (CW_W - n);
  endfunction

  function automatic void clear_book();
    for (int l = 0; l <= MAX_LEN; l++) begin
      next_code[l]   = '0;
      len_used_up[l] = 1'b0;
    end
    all_ones_hit    = 1'b0;
    entries_in_book = '0;
  endfunction

  // Walk the stored codewords, bumping past each prefix collision.
  // Returns 0 when a bump wraps past the top of the code space.
  function automatic bit find_free_codeword(input int unsigned len,
                                            output logic [CW_W-1:0] found);
    logic [CW_W-1:0] cand, m, bumped;
    int unsigned     k, lk;
    bit              hit;
    cand  = next_code[len];
    found = '0;
    do begin
      hit = 1'b0;
      k   = 0;
      while (k < entries_in_book && !hit) begin
        lk = stored_len[k];
        if (lk != 0) begin
          m = prefix_bits(lk < len ? lk : len);
          if ((stored_code[k] & m) == (cand & m)) begin
            bumped = (cand + ~m + 1'b1) & m;
            if (bumped <= cand) return 1'b0;
            cand = bumped;
            hit  = 1'b1;
          end
        end
        k++;
      end
    end while (hit);
    found = cand;
    return 1'b1;
  endfunction

  // Expected result for one entry; updates the book state
  function automatic codeword_result_t assign_codeword(input logic [LEN_W-1:0] len_in,
                                                       input logic last);
    codeword_result_t r;
    int unsigned      len, keep_len;
    logic [CW_W-1:0]  cw, nx;
    len      = len_in;
    cw       = '0;
    keep_len = 0;
    r.status = ST_OK;
    r.index  = entries_in_book[IDX_W-1:0];
    if (entries_in_book >= MAX_ENTRIES) begin
      r.status = ST_TABLE_FULL;
    end else begin
      if (len > MAX_LEN) begin
        r.status = ST_NO_FREE;
      end else if (len > 0) begin
        if (len_used_up[len]) begin
          r.status = ST_EXHAUSTED;
        end else if (!find_free_codeword(len, cw)) begin
          r.status = ST_NO_FREE;
          cw       = '0;
        end else begin
          nx = cw + (32'd1 << (CW_W - len));
          if (nx < cw) len_used_up[len] = 1'b1;
          next_code[len] = nx;
          if (cw == prefix_bits(len)) all_ones_hit = 1'b1;
          keep_len = len;
        end
      end
      stored_code[entries_in_book] = keep_len != 0 ? cw : '0;
      stored_len[entries_in_book]  = LEN_W'(keep_len);
      entries_in_book++;
    end
    // a clean last entry of a tree with no all-ones leaf is underspecified
    if (last && r.status == ST_OK && !all_ones_hit) r.status = ST_INCOMPLETE;
    r.codeword  = cw;
    r.book_done = last;
    if (last) clear_book();
    return r;
  endfunction

  // Results are checked before new entries are predicted in the same cycle
  always @(posedge clk) begin : watch
    codeword_result_t got, want;
    if (!rst_n) begin
      clear_book();
      expected_codewords.delete();
      mismatch_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.index     = out_tdata[7:0];
        got.codeword  = out_tdata[39:8];
        got.status    = out_tdata[42:40];
        got.book_done = out_tlast;
        if (expected_codewords.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result: idx %0d cw %h status %0d done %0b",
                     $time, got.index, got.codeword, got.status, got.book_done);
          mismatch_count++;
        end else begin
          want = expected_codewords.pop_front();
          if (got.index !== want.index || got.codeword !== want.codeword ||
              got.status !== want.status || got.book_done !== want.book_done) begin
            if (mismatch_count < 10)
              $display("%0t: mismatch: expected idx %0d cw %h status %0d done %0b,",
                       $time, want.index, want.codeword, want.status, want.book_done,
                       " got idx %0d cw %h status %0d done %0b",
                       got.index, got.codeword, got.status, got.book_done);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_codewords.push_back(assign_codeword(in_tdata[LEN_W-1:0], in_tlast));
    end
    pending_codewords = expected_codewords.size();
  end

endmodule

// ===== test/testbench.sv =====
// Top of the prefix codeword assigner testbench: clock, reset, entry stimulus
// with bursty sender and stalling receiver, and the final verdict.
// Depends on pcwa_pkg, prefix_codeword_assigner_top and codeword_checker.
`timescale 1ns / 1ps

module testbench
  import pcwa_pkg::*;
();

  localparam int MAX_ENTRIES  = 256;
  localparam int ITEM_TARGET  = 800;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 50;

  // Receiver stall patterns
  localparam int RX_FREE    = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_SPARSE  = 2;
  localparam int RX_PATTERN = 3;

  logic        clk;
  logic        rst_n;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;

  int mismatch_count;
  int pending_codewords;
  int cycle_count = 0;
  int entries_sent;
  int burst_left;
  bit steady_sender;

  // Entry lengths of the book about to be sent
  logic [LEN_W-1:0] book_len [0:511];
  int               book_size;

  prefix_codeword_assigner_top #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  codeword_checker #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tdata         (in_tdata),
    .in_tlast         (in_tlast),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .out_tdata        (out_tdata),
    .out_tlast        (out_tlast),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .mismatch_count   (mismatch_count),
    .pending_codewords(pending_codewords)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** prefix_codeword_assigner_top: FAILED **");
      $finish;
    end
  end

  task automatic add_entry(input int len);
    book_len[book_size] = LEN_W'(len);
    book_size++;
  endtask

  // Offer one entry; called and returning at a falling edge
  task automatic send_entry(input logic [LEN_W-1:0] len, input logic last);
    int r, idle;
    if (burst_left == 0) begin
      r = $urandom_range(0, 99);
      if (steady_sender || r < 55) idle = 0;
      else if (r < 90)             idle = $urandom_range(1, 8);
      else if (r < 98)             idle = $urandom_range(9, 60);
      else                         idle = $urandom_range(200, 500);
      if (idle > 0) begin
        in_tvalid <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, len};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    entries_sent++;
  endtask

  task automatic send_book();
    for (int j = 0; j < book_size; j++)
      send_entry(book_len[j], j == book_size - 1);
    book_size = 0;
  endtask

  // Complete tree by leaf splitting, optionally shuffled, with unused entries
  // mixed in and sometimes broken by a dropped or an extra leaf
  task automatic build_tree_book(input int leaves, input bit deepest_first);
    int depth [0:63];
    int count, pick, d, j, k, tmp;
    depth[0] = 0;
    count    = 1;
    while (count < leaves) begin
      pick = $urandom_range(0, count - 1);
      if (deepest_first)
        for (j = 0; j < count; j++)
          if (depth[j] >= depth[pick]) pick = j;
      d            = depth[pick];
      depth[pick]  = d + 1;
      depth[count] = d + 1;
      count++;
    end
    if ($urandom_range(0, 1))
      for (j = count - 1; j > 0; j--) begin
        k        = $urandom_range(0, j);
        tmp      = depth[j];
        depth[j] = depth[k];
        depth[k] = tmp;
      end
    for (j = 0; j < count; j++) begin
      if ($urandom_range(0, 9) == 0) add_entry(0);
      add_entry(depth[j]);
    end
    case ($urandom_range(0, 5))
      0:       if (book_size > 1) book_size--;
      1:       add_entry($urandom_range(1, 8));
      default: ;
    endcase
  endtask

  // Loose lengths: mostly short, some long, some unused or oversized
  task automatic build_random_book(input int n);
    int r;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 10)      add_entry(0);
      else if (r < 80) add_entry($urandom_range(1, 6));
      else if (r < 92) add_entry($urandom_range(7, MAX_LEN));
      else             add_entry($urandom_range(MAX_LEN + 1, 63));
    end
  endtask

  // Runs past the table size; mostly unused entries keep the scans short
  task automatic build_overflow_book();
    int n;
    n = MAX_ENTRIES + $urandom_range(1, 6);
    for (int j = 0; j < n; j++)
      if ($urandom_range(0, 7) == 0) add_entry($urandom_range(1, 10));
      else                           add_entry(0);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int r, overflow_books;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tlast       = 1'b0;
    burst_left     = 0;
    steady_sender  = 1'b0;
    entries_sent   = 0;
    book_size      = 0;
    overflow_books = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // two halves: complete tree
    add_entry(1); add_entry(1);
    send_book();
    // exhausted length, then a bump that wraps past the top
    add_entry(1); add_entry(1); add_entry(1); add_entry(MAX_LEN);
    send_book();
    // unused, oversized lengths, and a tree that never gets all ones
    add_entry(0); add_entry(MAX_LEN + 1); add_entry(63); add_entry(MAX_LEN);
    send_book();
    // collision against a longer code, then one against a shorter code leaves no free code at the end
    add_entry(2); add_entry(1); add_entry(2); add_entry(2);
    send_book();
    // bumps past longer codes, tree completes
    add_entry(3); add_entry(3); add_entry(2); add_entry(1);
    send_book();
    // lone 32-bit code: incomplete
    add_entry(MAX_LEN);
    send_book();

    while (entries_sent < ITEM_TARGET) begin
      steady_sender = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if ((overflow_books == 0 && entries_sent >= 250) ||
          (overflow_books == 1 && entries_sent >= 550)) begin
        build_overflow_book();
        overflow_books++;
      end else if (r < 45) begin
        build_tree_book($urandom_range(2, 16), 1'b0);
      end else if (r < 55) begin
        build_tree_book($urandom_range(20, MAX_LEN + 1), 1'b1);
      end else begin
        build_random_book($urandom_range(1, 16));
      end
      send_book();
    end
    in_tvalid <= 1'b0;

    while (pending_codewords != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_codewords == 0)
      $display("** prefix_codeword_assigner_top: PASSED **");
    else
      $display("** prefix_codeword_assigner_top: FAILED **");
    $finish;
  end

  // Receiver: stall patterns in segments, plus one long hold-off
  initial begin : receiver
    int       mode, seg_left, rx_cycles;
    bit       held_off;
    bit [7:0] pattern;
    out_tready = 1'b0;
    mode       = RX_FREE;
    seg_left   = 0;
    rx_cycles  = 0;
    held_off   = 1'b0;
    pattern    = 8'h01;
    wait (rst_n);
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (!held_off && rx_cycles == 3000) begin
        out_tready <= 1'b0;
        repeat (2000) @(negedge clk);
        held_off = 1'b1;
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(RX_FREE, RX_PATTERN);
        seg_left = $urandom_range(20, 300);
        pattern  = 8'($urandom) | 8'h01;
      end
      seg_left--;
      case (mode)
        RX_FREE:   out_tready <= 1'b1;
        RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          out_tready <= pattern[0];
          pattern = {pattern[0], pattern[7:1]};
        end
      endcase
    end
  end

endmodule

// ===== sim.f =====
rtl/core/pcwa_pkg.sv
rtl/core/prefix_codeword_assigner_top.sv
rtl/core/pcwa_checker.sv
test/codeword_checker.sv
test/testbench.sv
